@@ hdl/filetime_to_calendar_date_core_assert.svh @@
// assertion helpers shared by the date core
`ifndef FILETIME_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`define FILETIME_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// expression holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/ftcd_pkg.sv @@
package ftcd_pkg;

   // port widths
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 56;

   // register stages in the conversion pipeline
   localparam int unsigned PIPE_DEPTH = 19;

   // divisors
   localparam int unsigned DIV_MS     = 625;     // ticks per ms over 16
   localparam int unsigned DIV_DAY    = 84375;   // ms per day over 1024
   localparam int unsigned DAYS_ERA   = 146097;
   localparam int unsigned DIV_WEEK   = 7;
   localparam int unsigned MS_PER_S   = 1000;
   localparam int unsigned PER_MIN    = 60;
   localparam int unsigned DAYS_4Y    = 1460;
   localparam int unsigned DAYS_100Y  = 36524;
   localparam int unsigned DAYS_ERA_M = 146096;
   localparam int unsigned DAYS_YEAR  = 365;
   localparam int unsigned DAYS_OFF   = 584694;  // 0000-03-01 to 1601-01-01
   localparam int unsigned YEARS_ERA  = 400;
   localparam int unsigned MONTHS     = 12;

   // rounded-up reciprocals, exact for the full input width of each divider
   localparam logic [64:0] ONE_W   = 65'd1;
   localparam logic [32:0] RCP_MS  =
      33'(((ONE_W << 42) + 65'(DIV_MS) - ONE_W) / 65'(DIV_MS));
   localparam logic [32:0] RCP_DAY =
      33'(((ONE_W << 49) + 65'(DIV_DAY) - ONE_W) / 65'(DIV_DAY));
   localparam logic [24:0] RCP_ERA =
      25'(((ONE_W << 42) + 65'(DAYS_ERA) - ONE_W) / 65'(DAYS_ERA));
   localparam logic [24:0] RCP_WEEK =
      25'(((ONE_W << 27) + 65'(DIV_WEEK) - ONE_W) / 65'(DIV_WEEK));
   localparam logic [27:0] RCP_MSEC =
      28'(((ONE_W << 37) + 65'(MS_PER_S) - ONE_W) / 65'(MS_PER_S));
   localparam logic [17:0] RCP_MIN =
      18'(((ONE_W << 23) + 65'(PER_MIN) - ONE_W) / 65'(PER_MIN));
   localparam logic [18:0] RCP_4Y =
      19'(((ONE_W << 29) + 65'(DAYS_4Y) - ONE_W) / 65'(DAYS_4Y));
   localparam logic [18:0] RCP_YEAR =
      19'(((ONE_W << 27) + 65'(DAYS_YEAR) - ONE_W) / 65'(DAYS_YEAR));

   // word carried through the pipeline
   typedef struct packed {
      logic        ok;
      logic [58:0] y;      // ticks over 16
      logic [31:0] num;    // ms division partial dividend
      logic [21:0] quo;
      logic [49:0] ms;
      logic [31:0] numb;   // day division partial dividend
      logic [14:0] quob;
      logic [23:0] days;
      logic [26:0] msod;
      logic [23:0] z;
      logic [23:0] wk;
      logic [21:0] wq;
      logic [6:0]  era;
      logic [17:0] doe;
      logic [16:0] sod;
      logic [9:0]  mil;
      logic [10:0] mod;
      logic [5:0]  sec;
      logic [4:0]  hr;
      logic [5:0]  mnt;
      logic [2:0]  wd;
      logic [6:0]  qa;
      logic [2:0]  qb;
      logic        qc;
      logic [17:0] yn;
      logic [8:0]  yoe;
      logic [17:0] t365;
      logic [8:0]  doy;
      logic [3:0]  mp;
      logic [14:0] yr;
      logic [3:0]  mon;
      logic [4:0]  dom;
   } item_type;

   // result word
   typedef struct packed {
      logic        valid_res;
      logic [9:0]  millisecond;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [14:0] year;
   } rsp_type;

   // constant dividers by reciprocal multiplication
   function automatic logic [21:0] div_ms(input logic [31:0] v);
      logic [64:0] p;
      p = v * RCP_MS;
      return p[63:42];
   endfunction

   function automatic logic [14:0] div_day(input logic [31:0] v);
      logic [64:0] p;
      p = v * RCP_DAY;
      return p[63:49];
   endfunction

   function automatic logic [6:0] div_era(input logic [23:0] v);
      logic [48:0] p;
      p = v * RCP_ERA;
      return p[48:42];
   endfunction

   function automatic logic [21:0] div_week(input logic [23:0] v);
      logic [48:0] p;
      p = v * RCP_WEEK;
      return p[48:27];
   endfunction

   function automatic logic [16:0] div_msec(input logic [26:0] v);
      logic [54:0] p;
      p = v * RCP_MSEC;
      return p[53:37];
   endfunction

   function automatic logic [10:0] div_min(input logic [16:0] v);
      logic [34:0] p;
      p = v * RCP_MIN;
      return p[33:23];
   endfunction

   function automatic logic [6:0] div_4y(input logic [17:0] v);
      logic [36:0] p;
      p = v * RCP_4Y;
      return p[35:29];
   endfunction

   function automatic logic [8:0] div_year(input logic [17:0] v);
      logic [36:0] p;
      p = v * RCP_YEAR;
      return p[35:27];
   endfunction

   // first day of each month in a year that starts on march 1
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

@@ hdl/filetime_to_calendar_date_core.sv @@
// channel  | dir | word
// req      | in  | 64-bit tick count (100 ns since 1601-01-01)
// rsp      | out | calendar date and time of day, tuser = conversion valid
//
// one word per cycle sustained unless the output buffer is full
// 19 register stages, set by the chain of constant dividers (tick to ms,
// ms to day, days to era, year of era, month), then the output register
// synchronous reset clears the stage valid bits and the output buffer
// a two-entry output buffer keeps the pipeline moving while rsp stalls;
// when both entries are full the pipeline holds and req_tready drops
`include "filetime_to_calendar_date_core_assert.svh"

module filetime_to_calendar_date_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ftcd_pkg::REQ_DATA_W-1:0]   req_tdata,  // [63:0] tick_count
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [14:0] year, [18:15] month, [23:19] day_of_month, [26:24] weekday,
   // [31:27] hour, [37:32] minute, [43:38] second, [53:44] millisecond
   output logic [ftcd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser   // [0] valid_res
);
   import ftcd_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   item_type              pipe_ff [PIPE_DEPTH];
   item_type              pipe_in [PIPE_DEPTH];
   logic                  pipe_en;
   logic                  push, pop;
   rsp_type               res;
   logic                  out_vld_ff, out_vld_in, skd_vld_ff, skd_vld_in;
   rsp_type               out_ff, out_in, skd_ff, skd_in;
   logic                  out_ok;

   // pipeline moves unless the output buffer is full, no words taken in reset
   assign pipe_en    = !skd_vld_ff;
   assign req_tready = pipe_en && !reset;
   assign vld_in     = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   // stage logic
   always_comb begin
      logic [9:0]  r_ms1, r_ms2;
      logic [16:0] r_day1, r_day2;
      logic [3:0]  mp;
      logic [1:0]  cent;

      // unpack, first chunk of the ms division
      pipe_in[0]     = '0;
      pipe_in[0].ok  = !req_tdata[63];
      pipe_in[0].y   = req_tdata[62:4];
      pipe_in[0].num = 32'(req_tdata[62:41]);

      // ms division, top chunk
      pipe_in[1]     = pipe_ff[0];
      pipe_in[1].quo = div_ms(pipe_ff[0].num);

      pipe_in[2] = pipe_ff[1];
      r_ms1      = 10'(pipe_ff[1].num - 32'(pipe_ff[1].quo) * 32'(DIV_MS));
      pipe_in[2].ms[49:37] = pipe_ff[1].quo[12:0];
      pipe_in[2].num       = {r_ms1, pipe_ff[1].y[36:15]};

      // ms division, middle chunk
      pipe_in[3]     = pipe_ff[2];
      pipe_in[3].quo = div_ms(pipe_ff[2].num);

      pipe_in[4] = pipe_ff[3];
      r_ms2      = 10'(pipe_ff[3].num - 32'(pipe_ff[3].quo) * 32'(DIV_MS));
      pipe_in[4].ms[36:15] = pipe_ff[3].quo;
      pipe_in[4].num       = 32'({r_ms2, pipe_ff[3].y[14:0]});
      pipe_in[4].numb      = 32'(pipe_in[4].ms[49:25]);

      // last ms chunk and first day chunk side by side
      pipe_in[5]      = pipe_ff[4];
      pipe_in[5].quo  = div_ms(pipe_ff[4].num);
      pipe_in[5].quob = div_day(pipe_ff[4].numb);

      pipe_in[6] = pipe_ff[5];
      r_day1     = 17'(pipe_ff[5].numb - 32'(pipe_ff[5].quob) * 32'(DIV_DAY));
      pipe_in[6].ms[14:0]    = pipe_ff[5].quo[14:0];
      pipe_in[6].days[23:15] = pipe_ff[5].quob[8:0];
      pipe_in[6].numb        = {r_day1, pipe_in[6].ms[24:10]};

      // day division, low chunk
      pipe_in[7]      = pipe_ff[6];
      pipe_in[7].quob = div_day(pipe_ff[6].numb);

      pipe_in[8] = pipe_ff[7];
      r_day2     = 17'(pipe_ff[7].numb - 32'(pipe_ff[7].quob) * 32'(DIV_DAY));
      pipe_in[8].days[14:0] = pipe_ff[7].quob;
      pipe_in[8].msod       = {r_day2, pipe_ff[7].ms[9:0]};

      // day offsets, seconds of day
      pipe_in[9]     = pipe_ff[8];
      pipe_in[9].z   = pipe_ff[8].days + 24'(DAYS_OFF);
      pipe_in[9].wk  = pipe_ff[8].days + 24'd1;
      pipe_in[9].sod = div_msec(pipe_ff[8].msod);

      // era, week count, millisecond
      pipe_in[10]     = pipe_ff[9];
      pipe_in[10].era = div_era(pipe_ff[9].z);
      pipe_in[10].wq  = div_week(pipe_ff[9].wk);
      pipe_in[10].mil = 10'(pipe_ff[9].msod - 27'(pipe_ff[9].sod) * 27'(MS_PER_S));

      // day of era, weekday, minute of day
      pipe_in[11]     = pipe_ff[10];
      pipe_in[11].doe = 18'(pipe_ff[10].z - 24'(pipe_ff[10].era) * 24'(DAYS_ERA));
      pipe_in[11].wd  = 3'(pipe_ff[10].wk - 24'(pipe_ff[10].wq) * 24'(DIV_WEEK));
      pipe_in[11].mod = div_min(pipe_ff[10].sod);

      // leap corrections, second
      pipe_in[12]    = pipe_ff[11];
      pipe_in[12].qa = div_4y(pipe_ff[11].doe);
      pipe_in[12].qb = 3'(pipe_ff[11].doe >= 18'(DAYS_100Y))
                     + 3'(pipe_ff[11].doe >= 18'(2 * DAYS_100Y))
                     + 3'(pipe_ff[11].doe >= 18'(3 * DAYS_100Y))
                     + 3'(pipe_ff[11].doe >= 18'(DAYS_ERA_M));
      pipe_in[12].qc  = (pipe_ff[11].doe == 18'(DAYS_ERA_M));
      pipe_in[12].sec = 6'(pipe_ff[11].sod - 17'(pipe_ff[11].mod) * 17'(PER_MIN));

      // corrected day count, hour
      pipe_in[13]    = pipe_ff[12];
      pipe_in[13].yn = pipe_ff[12].doe - 18'(pipe_ff[12].qa) + 18'(pipe_ff[12].qb)
                     - 18'(pipe_ff[12].qc);
      pipe_in[13].hr = 5'(div_min(17'(pipe_ff[12].mod)));

      // year of era, minute
      pipe_in[14]     = pipe_ff[13];
      pipe_in[14].yoe = div_year(pipe_ff[13].yn);
      pipe_in[14].mnt = 6'(pipe_ff[13].mod - 11'(pipe_ff[13].hr) * 11'(PER_MIN));

      // days before the year of era
      pipe_in[15] = pipe_ff[14];
      cent = 2'(pipe_ff[14].yoe >= 9'd100) + 2'(pipe_ff[14].yoe >= 9'd200)
           + 2'(pipe_ff[14].yoe >= 9'd300);
      pipe_in[15].t365 = 18'(18'(pipe_ff[14].yoe) * 18'(DAYS_YEAR)
                       + 18'(pipe_ff[14].yoe >> 2) - 18'(cent));

      // day of year
      pipe_in[16]     = pipe_ff[15];
      pipe_in[16].doy = 9'(pipe_ff[15].doe - pipe_ff[15].t365);

      // month of a march-based year
      pipe_in[17] = pipe_ff[16];
      mp = '0;
      for (int i = 1; i < MONTHS; i++) begin
         if (pipe_ff[16].doy >= month_start(4'(i))) begin
            mp = 4'(i);
         end
      end
      pipe_in[17].mp = mp;

      // day, calendar month and year
      pipe_in[18]     = pipe_ff[17];
      pipe_in[18].dom = 5'(pipe_ff[17].doy - month_start(pipe_ff[17].mp) + 9'd1);
      pipe_in[18].mon = (pipe_ff[17].mp < 4'd10) ? pipe_ff[17].mp + 4'd3
                                                 : pipe_ff[17].mp - 4'd9;
      pipe_in[18].yr  = 15'(16'(pipe_ff[17].yoe)
                      + 16'(pipe_ff[17].era) * 16'(YEARS_ERA)
                      + 16'(pipe_in[18].mon <= 4'd2));
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pipe_ff <= pipe_in;
      end
   end

   // result word, zero when rejected
   always_comb begin
      res = '0;
      if (pipe_ff[PIPE_DEPTH-1].ok) begin
         res.valid_res    = 1'b1;
         res.year         = pipe_ff[PIPE_DEPTH-1].yr;
         res.month        = pipe_ff[PIPE_DEPTH-1].mon;
         res.day_of_month = pipe_ff[PIPE_DEPTH-1].dom;
         res.weekday      = pipe_ff[PIPE_DEPTH-1].wd;
         res.hour         = pipe_ff[PIPE_DEPTH-1].hr;
         res.minute       = pipe_ff[PIPE_DEPTH-1].mnt;
         res.second       = pipe_ff[PIPE_DEPTH-1].sec;
         res.millisecond  = pipe_ff[PIPE_DEPTH-1].mil;
      end
   end

   // two-entry output buffer
   assign push = pipe_en && vld_ff[PIPE_DEPTH-1];
   assign pop  = out_vld_ff && rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      skd_vld_in = skd_vld_ff;
      skd_in     = skd_ff;
      if (pop) begin
         if (skd_vld_ff) begin
            out_in     = skd_ff;
            skd_vld_in = 1'b0;
         end else begin
            out_vld_in = push;
            out_in     = res;
         end
      end else if (push) begin
         if (out_vld_ff) begin
            skd_vld_in = 1'b1;
            skd_in     = res;
         end else begin
            out_vld_in = 1'b1;
            out_in     = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skd_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         skd_vld_ff <= skd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skd_ff <= skd_in;
   end

   // output ports
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.valid_res;
   assign rsp_tdata  = {2'b00, out_ff.millisecond, out_ff.second, out_ff.minute,
                        out_ff.hour, out_ff.weekday, out_ff.day_of_month,
                        out_ff.month, out_ff.year};

   assign out_ok = out_vld_ff && out_ff.valid_res;

   // checks
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skd_vld_ff, out_vld_ff, "skid without out")
   `ASSERT_IMPLIES(a_skid_on_stall, clock, reset, $rose(skd_vld_ff), $past(out_vld_ff && !rsp_tready), "skid fill")
   `ASSERT_IMPLIES(a_reject_zero, clock, reset, out_vld_ff && !out_ff.valid_res, rsp_tdata == '0, "reject")
   `ASSERT_IMPLIES(a_date_range, clock, reset, out_ok, out_ff.month >= 4'd1 && out_ff.month <= 4'd12, "month")
   `ASSERT_IMPLIES(a_time_range, clock, reset, out_ok, out_ff.hour <= 5'd23 && out_ff.weekday <= 3'd6, "time")
   `ASSERT_IMPLIES(a_day_range, clock, reset, out_ok, out_ff.day_of_month != 5'd0, "day")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ftcd_pkg::*;

   localparam logic [63:0] DAY_TICKS    = 64'd864000000000;
   localparam int          DIR_ROWS     = 22;
   localparam int          RANDOM_WORDS = 750;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          LONG_HOLD    = 120;
   localparam int          HOLD_AT_WORD = 300;
   localparam int          PAUSE_AT     = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // dates still owed by the block, oldest first
   rsp_type     pending_dates [$];
   int unsigned error_count;
   int unsigned words_sent;
   int unsigned words_rejected;
   int unsigned dates_checked;
   bit          tx_burst;
   int unsigned tx_left;

   filetime_to_calendar_date_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // valid date with every field given
   function automatic rsp_type date_time(int unsigned yr, int unsigned mo, int unsigned dd,
                                         int unsigned wd, int unsigned hh, int unsigned mi,
                                         int unsigned ss, int unsigned ms);
      rsp_type r;
      r.valid_res    = 1'b1;
      r.year         = 15'(yr);
      r.month        = 4'(mo);
      r.day_of_month = 5'(dd);
      r.weekday      = 3'(wd);
      r.hour         = 5'(hh);
      r.minute       = 6'(mi);
      r.second       = 6'(ss);
      r.millisecond  = 10'(ms);
      return r;
   endfunction

   // calendar date and time of day for a count of 100 ns ticks since 1601
   function automatic rsp_type date_of_ticks(logic [63:0] ticks);
      rsp_type     r;
      logic [63:0] ms, days, msod, shifted, era, doe, yoe, doy, mp, dd, mo, yr;
      r = '0;
      if (ticks[63]) return r;
      ms      = ticks / 64'd10000;
      days    = ms / 64'd86400000;
      msod    = ms % 64'd86400000;
      // shift so that day 0 is 0000-03-01 and split into 400-year eras
      shifted = days + 64'd584694;
      era     = shifted / 64'd146097;
      doe     = shifted - era * 64'd146097;
      yoe     = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy     = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp      = (64'd5 * doy + 64'd2) / 64'd153;
      dd      = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
      mo      = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
      yr      = yoe + era * 64'd400 + ((mo <= 64'd2) ? 64'd1 : 64'd0);
      r.valid_res    = 1'b1;
      r.year         = yr[14:0];
      r.month        = mo[3:0];
      r.day_of_month = dd[4:0];
      r.weekday      = 3'((days + 64'd1) % 64'd7);
      r.millisecond  = 10'(msod % 64'd1000);
      msod           = msod / 64'd1000;
      r.second       = 6'(msod % 64'd60);
      msod           = msod / 64'd60;
      r.minute       = 6'(msod % 64'd60);
      r.hour         = 5'(msod / 64'd60);
      return r;
   endfunction

   // directed words: extremes, floor to ms, day and leap boundaries, bit 63
   typedef struct {
      logic [63:0] ticks;
      bit          typed;
      rsp_type     date;
   } stim_row_type;

   stim_row_type stim_table [DIR_ROWS] = '{
      '{64'd0,                  1'b1, date_time(1601, 1, 1, 1, 0, 0, 0, 0)},
      '{64'd9999,               1'b1, date_time(1601, 1, 1, 1, 0, 0, 0, 0)},
      '{64'd10000,              1'b1, date_time(1601, 1, 1, 1, 0, 0, 0, 1)},
      '{DAY_TICKS - 64'd1,      1'b1, date_time(1601, 1, 1, 1, 23, 59, 59, 999)},
      '{DAY_TICKS,              1'b1, date_time(1601, 1, 2, 2, 0, 0, 0, 0)},
      '{64'd116444736000000000, 1'b1, date_time(1970, 1, 1, 4, 0, 0, 0, 0)},
      '{64'h8000000000000000,   1'b1, '0},
      '{64'hFFFFFFFFFFFFFFFF,   1'b1, '0},
      '{64'h7FFFFFFFFFFFFFFF,   1'b0, '0},
      '{DAY_TICKS * 64'd364,    1'b0, '0},
      '{DAY_TICKS * 64'd1154,   1'b0, '0},
      '{DAY_TICKS * 64'd1155 - 64'd1,   1'b0, '0},
      '{DAY_TICKS * 64'd36217,  1'b0, '0},
      '{DAY_TICKS * 64'd36218,  1'b0, '0},
      '{DAY_TICKS * 64'd145790, 1'b0, '0},
      '{DAY_TICKS * 64'd145791 - 64'd1, 1'b0, '0},
      '{DAY_TICKS * 64'd146097 - 64'd1, 1'b0, '0},
      '{DAY_TICKS * 64'd146097, 1'b0, '0},
      '{64'd12345678901234567,  1'b0, '0},
      '{64'h4000000000000000,   1'b0, '0},
      '{64'h5555555555555555,   1'b0, '0},
      '{64'hAAAAAAAAAAAAAAAA,   1'b1, '0}
   };

   // random tick count, weighted toward valid dates and boundaries
   function automatic logic [63:0] random_ticks();
      logic [63:0] t;
      logic [63:0] d;
      t = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: ;
         2, 3, 4: t[63] = 1'b0;
         5: t = 64'h7FFFFFFFFFFFFFFF - 64'($urandom_range(0, 100000));
         6: begin
            d = 64'($urandom_range(0, 10675198));
            case ($urandom_range(0, 2))
               0:       t = d * DAY_TICKS + DAY_TICKS - 64'd1;
               1:       t = d * DAY_TICKS;
               default: t = d * DAY_TICKS + 64'($urandom_range(0, 9999));
            endcase
         end
         7: t = 64'($urandom_range(0, 200000)) * DAY_TICKS + t % DAY_TICKS;
         8: begin
            t[63] = 1'b0;
            t = (t / 64'd10000) * 64'd10000 + ($urandom_range(0, 1) ? 64'd9999 : 64'd0);
         end
         default: t = {1'b1, 47'd0, 16'($urandom)};
      endcase
      return t;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // send one word after a random gap, record its date once accepted
   task automatic send_word(logic [63:0] ticks, rsp_type date);
      int unsigned gap;
      if (tx_left == 0) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         tx_left  = $urandom_range(10, 40);
      end
      tx_left--;
      gap = tx_burst ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ticks;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_dates.push_back(date);
      words_sent++;
      if (ticks[63]) words_rejected++;
      @(negedge clock);
   endtask

   // stop offering and wait until every owed date has come back
   task automatic drain_dates();
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // timeout
   initial begin
      #400000;
      $display("%0t: timeout with %0d dates outstanding", $time, pending_dates.size());
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stalls, one long hold, check every word
   initial begin : date_sink
      int unsigned gap;
      int unsigned left;
      bit          burst;
      bit          held;
      rsp_type     got;
      rsp_type     want;
      rsp_tready = 1'b0;
      left       = 0;
      burst      = 1'b0;
      held       = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (left == 0) begin
            burst = ($urandom_range(0, 3) == 0);
            left  = $urandom_range(10, 40);
         end
         left--;
         gap = burst ? 0 : $urandom_range(0, 5);
         if (!held && dates_checked == HOLD_AT_WORD) begin
            gap  = LONG_HOLD;
            held = 1'b1;
         end
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tuser, rsp_tdata[53:0]};
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_dates.pop_front();
            compare_field("valid_res", want.valid_res, got.valid_res);
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
            compare_field("millisecond", want.millisecond, got.millisecond);
            dates_checked++;
         end
         @(negedge clock);
      end
   end

   // reset, directed table, random words, drain and verdict
   initial begin : tick_source
      logic [63:0] ticks;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      error_count    = 0;
      words_sent     = 0;
      words_rejected = 0;
      dates_checked  = 0;
      tx_burst       = 1'b0;
      tx_left        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_word(stim_table[i].ticks,
                   stim_table[i].typed ? stim_table[i].date
                                       : date_of_ticks(stim_table[i].ticks));
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // one pause with the pipeline fully empty
         if (i == PAUSE_AT) drain_dates();
         ticks = random_ticks();
         send_word(ticks, date_of_ticks(ticks));
      end

      drain_dates();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("converted %0d tick counts, %0d rejected for bit 63, %0d dates checked",
               words_sent, words_rejected, dates_checked);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filetime_to_calendar_date_core.f @@
+incdir+hdl
hdl/ftcd_pkg.sv
hdl/filetime_to_calendar_date_core.sv
sim/testbench.sv
